[rtl/core/discharge_pulse_counter_macros.svh]
// Assertion macros used by the discharge pulse counter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DISCHARGE_PULSE_COUNTER_MACROS_SVH
`define DISCHARGE_PULSE_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dpc assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dpc assertion failed");

`endif

[rtl/core/dpc_pkg.sv]
// Shared types and constants for the discharge pulse counter.
// No dependencies; used by every module of the block.
package dpc_pkg;

  localparam int MAX_FRAME   = 16384;
  localparam int POS_W       = $clog2(MAX_FRAME);
  localparam int MAG_W       = 15;
  localparam int THRESH_W    = 15;
  localparam int GAP_W       = 14;
  localparam int COUNT_W     = 8;
  localparam int QUIET_W     = 6;
  localparam int WIDTH_W     = 14;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_IDX_W   = 2;

  localparam logic [POS_W-1:0]   POS_MAX     = POS_W'(MAX_FRAME - 1);
  localparam logic [QUIET_W-1:0] QUIET_LIMIT = QUIET_W'(50);
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = WIDTH_W'(10);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MIN_GAP   = 2'd1,
    REG_COUNT_LOW = 2'd2,
    REG_COUNT_HIGH = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [THRESH_W-1:0] pulse_threshold;
    logic [GAP_W-1:0]    min_gap;
    logic [COUNT_W-1:0]  count_low;
    logic [COUNT_W-1:0]  count_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pulse_threshold: THRESH_W'(16384),
    min_gap:         GAP_W'(3500),
    count_low:       COUNT_W'(1),
    count_high:      COUNT_W'(5)
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic               frame_end;
  } sample_in_t;

  typedef struct packed {
    logic               discharge_found;
    logic [COUNT_W-1:0] event_total;
    logic [COUNT_W-1:0] spaced_total;
  } result_t;

  // Beat handed from the input register to the tracker, flagged by the advance strobe.
  typedef struct packed {
    logic             step;
    logic             last;
    logic [MAG_W-1:0] mag;
  } step_t;

endpackage

[rtl/core/discharge_pulse_counter.sv]
// Top level of the discharge pulse counter: config registers, input and result stages.
// Depends on dpc_pkg and dpc_frame_tracker.
//
// Counts partial-discharge-like pulses in a frame of signed Q1.15 filtered samples and
// gives one verdict beat per frame. A sample whose magnitude exceeds pulse_threshold
// arms an event; the event closes after more than 50 samples at or below a third of its
// first peak, and counts if more than 10 louder samples came in between. Counted events
// more than min_gap samples after the previous one also count as spaced. On the beat with
// frame_end set, the block emits discharge_found (both counts strictly between count_low
// and count_high) with the two saturating totals, then clears all frame state. Beats
// without frame_end give no output.
// Rate: one sample per clock, sustained, except for the stall below. A sample is taken into an
// input register (its magnitude already formed), then the tracker updates its state from it;
// the verdict of a last sample is formed from the tracker's updated state and captured in the
// output register as that sample leaves the input register. The tracker's state update is
// what sets the pace. Input stalls only when a verdict waits in the output register and the
// next last sample would need it.
// Config writes (index 0..3: threshold, min_gap, count_low, count_high) take effect at
// once and belong to idle periods between frames.
module discharge_pulse_counter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  dpc_pkg::sample_in_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output dpc_pkg::result_t                     out_data_o
);
  import dpc_pkg::*;

  // configuration registers
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_THRESHOLD:  cfg_d.pulse_threshold = cfg_data_i[THRESH_W-1:0];
        REG_MIN_GAP:    cfg_d.min_gap         = cfg_data_i[GAP_W-1:0];
        REG_COUNT_LOW:  cfg_d.count_low       = cfg_data_i[COUNT_W-1:0];
        REG_COUNT_HIGH: cfg_d.count_high      = cfg_data_i[COUNT_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input stage: magnitude with -32768 saturating to 32767
  logic             s1_valid_q;
  logic             s1_last_q;
  logic [MAG_W-1:0] s1_mag_q;
  logic [MAG_W-1:0] mag_in;
  logic [15:0]      neg_sample;
  logic             advance;
  logic             in_beat;
  logic             out_valid_q;
  result_t          out_data_q;
  result_t          verdict;
  step_t            step;

  assign neg_sample = 16'(-in_data_i.sample);

  always_comb begin
    if (!in_data_i.sample[15]) begin
      mag_in = in_data_i.sample[MAG_W-1:0];
    end else if (neg_sample[15]) begin
      mag_in = '1;                      // most negative code
    end else begin
      mag_in = neg_sample[MAG_W-1:0];
    end
  end

  // a non-last beat never needs the output register
  assign advance    = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_beat    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_mag_q  <= mag_in;
      s1_last_q <= in_data_i.frame_end;
    end
  end

  assign step.step = advance;
  assign step.last = s1_last_q;
  assign step.mag  = s1_mag_q;

  dpc_frame_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .step_i   (step),
    .result_o (verdict)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      out_data_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/dpc_frame_tracker.sv]
// Per-frame event tracking state and verdict logic for the discharge pulse counter.
// Depends on dpc_pkg.
module dpc_frame_tracker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpc_pkg::cfg_t    cfg_i,
  input  dpc_pkg::step_t   step_i,
  output dpc_pkg::result_t result_o
);
  import dpc_pkg::*;

  logic               armed_q, armed_d;
  logic [MAG_W-1:0]   peak_q, peak_d;
  logic [QUIET_W-1:0] quiet_q, quiet_d;
  logic [WIDTH_W-1:0] width_q, width_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   prev_pos_q, prev_pos_d;
  logic               seen_q, seen_d;
  logic [COUNT_W-1:0] event_q, event_d;
  logic [COUNT_W-1:0] spaced_q, spaced_d;

  logic [MAG_W+1:0]   mag_x3;
  logic [POS_W-1:0]   gap;
  logic               is_quiet;

  assign mag_x3   = {1'b0, step_i.mag, 1'b0} + {2'b00, step_i.mag};
  assign is_quiet = mag_x3 <= {2'b00, peak_q};
  assign gap      = pos_q - prev_pos_q;

  always_comb begin
    armed_d    = armed_q;
    peak_d     = peak_q;
    quiet_d    = quiet_q;
    width_d    = width_q;
    prev_pos_d = prev_pos_q;
    seen_d     = seen_q;
    event_d    = event_q;
    spaced_d   = spaced_q;

    if (armed_q) begin
      if (is_quiet) begin
        quiet_d = quiet_q + QUIET_W'(1);
      end else begin
        quiet_d = '0;
        if (width_q != WIDTH_MAX) width_d = width_q + WIDTH_W'(1);
      end
      if (quiet_d > QUIET_LIMIT) begin
        if (width_d > WIDTH_LIMIT) begin
          if (event_q != COUNT_MAX) event_d = event_q + COUNT_W'(1);
          if (!seen_q || (GAP_W'(gap) > cfg_i.min_gap)) begin
            if (spaced_q != COUNT_MAX) spaced_d = spaced_q + COUNT_W'(1);
          end
          prev_pos_d = pos_q;
          seen_d     = 1'b1;
        end
        armed_d = 1'b0;
        peak_d  = '0;
        quiet_d = '0;
        width_d = '0;
      end
    end else if (step_i.mag > cfg_i.pulse_threshold) begin
      armed_d = 1'b1;
      peak_d  = step_i.mag;
    end

    pos_d = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : pos_q;

    result_o.discharge_found = (event_d > cfg_i.count_low) && (event_d < cfg_i.count_high) &&
                               (spaced_d > cfg_i.count_low) && (spaced_d < cfg_i.count_high);
    result_o.event_total  = event_d;
    result_o.spaced_total = spaced_d;

    // frame end: verdict taken from the updated counts, then clear
    if (step_i.last) begin
      armed_d    = 1'b0;
      peak_d     = '0;
      quiet_d    = '0;
      width_d    = '0;
      pos_d      = '0;
      prev_pos_d = '0;
      seen_d     = 1'b0;
      event_d    = '0;
      spaced_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      peak_q     <= '0;
      quiet_q    <= '0;
      width_q    <= '0;
      pos_q      <= '0;
      prev_pos_q <= '0;
      seen_q     <= 1'b0;
      event_q    <= '0;
      spaced_q   <= '0;
    end else if (step_i.step) begin
      armed_q    <= armed_d;
      peak_q     <= peak_d;
      quiet_q    <= quiet_d;
      width_q    <= width_d;
      pos_q      <= pos_d;
      prev_pos_q <= prev_pos_d;
      seen_q     <= seen_d;
      event_q    <= event_d;
      spaced_q   <= spaced_d;
    end
  end

endmodule

[rtl/core/dpc_checker.sv]
// Port-level checker for the discharge pulse counter, bound to the top level.
// Depends on dpc_pkg and discharge_pulse_counter_macros.svh.
`include "discharge_pulse_counter_macros.svh"

module dpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input dpc_pkg::result_t               out_data_o
);
  import dpc_pkg::*;

  // a waiting verdict stays put
  `DPC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // spaced discharges are a subset of all discharges
  `DPC_ASSERT_NOW(a_spaced_le_total, out_valid_o,
                  out_data_o.spaced_total <= out_data_o.event_total)

  // a positive verdict needs nonzero counts below saturation
  `DPC_ASSERT_NOW(a_found_counts, out_valid_o && out_data_o.discharge_found,
                  out_data_o.event_total != '0 && out_data_o.spaced_total != '0 &&
                  out_data_o.event_total != COUNT_MAX)

  // without a pending verdict, the input side never stalls
  `DPC_ASSERT_NOW(a_no_stall, !out_valid_o, in_ready_o)

endmodule

bind discharge_pulse_counter dpc_checker u_dpc_checker (.*);

[tb/sv/discharge_pulse_counter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for discharge_pulse_counter: random valid/ready traffic, shadow model.
// Depends on dpc_pkg and the discharge_pulse_counter RTL; needs no other files.
module discharge_pulse_counter_tb;
  import dpc_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 400;   // long receiver hold-off, fills the block
  localparam int unsigned STALL_LIMIT     = 3000;  // cycles without a beat while work is open
  localparam int unsigned SETTLE_CYCLES   = 8;     // idle clocks after the queues drain

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we    = 1'b0;
  reg_idx_e              cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic       in_valid  = 1'b0;
  sample_in_t in_data   = '0;
  logic       in_ready;
  logic       out_valid;
  logic       out_ready = 1'b0;
  result_t    out_data;

  discharge_pulse_counter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copy plus frame state, updated per accepted beat.
  // ---------------------------------------------------------------------------
  cfg_t settings = CFG_RESET;

  logic               armed_now      = 1'b0;
  logic [MAG_W-1:0]   peak_level     = '0;
  logic [QUIET_W-1:0] quiet_len      = '0;
  logic [WIDTH_W-1:0] width_len      = '0;
  logic [POS_W-1:0]   sample_pos     = '0;
  logic [POS_W-1:0]   last_event_pos = '0;
  logic               had_event      = 1'b0;
  logic [COUNT_W-1:0] event_tally    = '0;
  logic [COUNT_W-1:0] spaced_tally   = '0;

  result_t    verdicts_due[$];   // verdicts still owed by the block, oldest first
  sample_in_t pending[$];        // beats waiting for the sender

  int unsigned beats_queued   = 0;
  int unsigned beats_taken    = 0;
  int unsigned verdicts_taken = 0;
  int unsigned mismatches     = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned send_wait      = 0;
  int unsigned send_calm      = 0;
  int unsigned take_wait      = 0;
  int unsigned take_calm      = 0;

  function automatic logic within_bounds(logic [COUNT_W-1:0] c);
    return (c > settings.count_low) && (c < settings.count_high);
  endfunction

  // One sample through the discharge tracker; a frame_end beat owes one verdict.
  function automatic void track_sample(sample_in_t beat);
    logic [15:0]      flipped;
    logic [MAG_W-1:0] mag;
    logic [16:0]      triple;
    result_t          verdict;
    // -32768 has no positive twin: it saturates to full scale
    if (beat.sample[15]) begin
      flipped = 16'(-beat.sample);
      mag = flipped[15] ? 15'h7FFF : flipped[14:0];
    end else begin
      mag = beat.sample[14:0];
    end
    triple = 17'(mag) * 17'd3;
    if (armed_now) begin
      if (triple <= 17'(peak_level)) begin
        quiet_len++;
      end else begin
        quiet_len = '0;
        if (width_len != WIDTH_MAX) width_len++;
      end
      if (quiet_len > QUIET_LIMIT) begin
        // event closes; only wide ones count, first one of a frame is always spaced
        if (width_len > WIDTH_LIMIT) begin
          if (event_tally != COUNT_MAX) event_tally++;
          if (!had_event || (sample_pos - last_event_pos) > settings.min_gap) begin
            if (spaced_tally != COUNT_MAX) spaced_tally++;
          end
          last_event_pos = sample_pos;
          had_event      = 1'b1;
        end
        armed_now  = 1'b0;
        peak_level = '0;
        quiet_len  = '0;
        width_len  = '0;
      end
    end else if (mag > settings.pulse_threshold) begin
      // arming sample only sets the peak
      armed_now  = 1'b1;
      peak_level = mag;
    end
    if (sample_pos != POS_MAX) sample_pos++;
    if (beat.frame_end) begin
      verdict.discharge_found = within_bounds(event_tally) && within_bounds(spaced_tally);
      verdict.event_total     = event_tally;
      verdict.spaced_total    = spaced_tally;
      verdicts_due.push_back(verdict);
      armed_now      = 1'b0;
      peak_level     = '0;
      quiet_len      = '0;
      width_len      = '0;
      sample_pos     = '0;
      last_event_pos = '0;
      had_event      = 1'b0;
      event_tally    = '0;
      spaced_tally   = '0;
    end
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_verdict(result_t got);
    result_t want;
    if (verdicts_due.size() == 0) begin
      report_mismatch($sformatf("verdict with none owed: found=%0b events=%0d spaced=%0d",
                                got.discharge_found, got.event_total, got.spaced_total));
    end else begin
      want = verdicts_due.pop_front();
      if (got.discharge_found !== want.discharge_found ||
          got.event_total !== want.event_total || got.spaced_total !== want.spaced_total) begin
        report_mismatch($sformatf(
          "verdict %0d expected found=%0b events=%0d spaced=%0d, got found=%0b events=%0d spaced=%0d",
          verdicts_taken, want.discharge_found, want.event_total, want.spaced_total,
          got.discharge_found, got.event_total, got.spaced_total));
      end
    end
  endfunction

  // Idle length for either side: mostly none or short, a few long, plus calm stretches.
  function automatic int unsigned pick_pause(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 150);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: drives one beat at a time from pending, with random gaps after each beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_sample(in_data);
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_data   <= pending.pop_front();
          in_valid  <= 1'b1;
          send_wait = pick_pause(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each verdict beat; random stalls, one long hold-off after the
  // third verdict so the output register stays full and the input backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_verdict(out_data);
        verdicts_taken++;
        if (verdicts_taken == 3) take_wait = HOLD_OFF_CYCLES;
      end
      if (take_wait != 0) begin
        take_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        take_wait = pick_pause(take_calm);
      end
    end
  end

  // Watchdog: only counts while beats or verdicts are still outstanding.
  always @(posedge clk_i) begin
    if (rst_ni && (beats_taken != beats_queued || verdicts_due.size() != 0) &&
        !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (zero time, fill pending).
  // ---------------------------------------------------------------------------
  function automatic void push_beat(logic signed [15:0] s, logic last);
    pending.push_back(sample_in_t'{sample: s, frame_end: last});
    beats_queued++;
  endfunction

  // Magnitude to sample with random sign; full scale may come out as -32768.
  function automatic logic signed [15:0] signed_of(int unsigned mag);
    logic signed [15:0] v;
    v = 16'(mag);
    if ($urandom_range(0, 1)) v = (mag == 32767 && $urandom_range(0, 1)) ? 16'sh8000 : -v;
    return v;
  endfunction

  // Arming sample, loud_n loud samples (optionally with short quiet dips), then quiet_n
  // quiet samples. Loud/quiet levels hit the one-third-of-peak edge now and then.
  function automatic void add_pulse(int unsigned loud_n, int unsigned quiet_n, bit spread);
    int unsigned peak;
    int unsigned third;
    peak  = (settings.pulse_threshold == 15'h7FFF) ? 32767 :
            $urandom_range(settings.pulse_threshold + 1, 32767);
    third = peak / 3;
    push_beat(signed_of(peak), 1'b0);
    repeat (loud_n) begin
      push_beat(signed_of(($urandom_range(0, 3) == 0) ? third + 1 :
                          $urandom_range(third + 1, 32767)), 1'b0);
      if (spread && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 8)) push_beat(signed_of($urandom_range(0, third)), 1'b0);
      end
    end
    repeat (quiet_n) begin
      push_beat(signed_of(($urandom_range(0, 3) == 0) ? third : $urandom_range(0, third)),
                1'b0);
    end
  endfunction

  // Half raw noise frames, half frames of pulses that straddle the width and quiet limits.
  function automatic void add_random_frame();
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(0, 19)) push_beat(16'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(0, 4)) begin
        repeat ($urandom_range(0, 20)) begin
          push_beat(signed_of($urandom_range(0, settings.pulse_threshold)), 1'b0);
        end
        add_pulse($urandom_range(6, 16), $urandom_range(46, 56), 1'b1);
      end
    end
    push_beat(16'($urandom), 1'b1);
  endfunction

  task automatic wait_drained();
    while (beats_taken != beats_queued || verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Registers written back to back; upper data bits carry junk to exercise masking.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] thr_raw, gap_raw, low_raw,
                              high_raw);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr_raw;
    @(posedge clk_i);
    cfg_index <= REG_MIN_GAP;
    cfg_data  <= gap_raw;
    @(posedge clk_i);
    cfg_index <= REG_COUNT_LOW;
    cfg_data  <= low_raw;
    @(posedge clk_i);
    cfg_index <= REG_COUNT_HIGH;
    cfg_data  <= high_raw;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings.pulse_threshold = thr_raw[THRESH_W-1:0];
    settings.min_gap         = gap_raw[GAP_W-1:0];
    settings.count_low       = low_raw[COUNT_W-1:0];
    settings.count_high      = high_raw[COUNT_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence: directed frames at reset settings, then ten phases of random frames
  // (the first at reset settings, nine with new settings), then a frame left open.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] thr_raw, gap_raw, low_raw, high_raw;
    int unsigned phase;
    int unsigned phase_start;
    int unsigned phase_frames;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // lone last sample: empty verdict
    push_beat(16'sd0, 1'b1);
    // level equal to threshold does not arm; just above does
    push_beat(16'sd16384, 1'b0);
    push_beat(-16'sd16385, 1'b0);
    push_beat(16'sd32767, 1'b0);
    push_beat(16'sh8000, 1'b0);
    push_beat(16'sd5461, 1'b0);     // 3x below peak: quiet
    push_beat(16'sd5462, 1'b0);     // 3x above peak: loud
    push_beat(-16'sd1, 1'b0);
    push_beat(16'sd1, 1'b1);        // frame ends while armed
    // arming on the last sample itself
    push_beat(16'sh8000, 1'b1);
    // most negative sample saturates; exact third-of-peak edge
    push_beat(-16'sd32767, 1'b0);
    push_beat(16'sd10922, 1'b0);
    push_beat(16'sd10923, 1'b0);
    push_beat(16'sh8000, 1'b1);
    // alternating bit patterns
    push_beat(16'sh5555, 1'b0);
    push_beat(16'shAAAA, 1'b0);
    push_beat(16'sh7FFF, 1'b0);
    push_beat(16'sd0, 1'b1);

    for (phase = 0; phase < 10; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1: begin
            thr_raw = '0; gap_raw = '0; low_raw = '0; high_raw = 15'd255;
          end
          2: begin
            thr_raw = 15'h7FFF; gap_raw = 15'h7FFF; low_raw = 15'h7FFF; high_raw = 15'h7F00;
          end
          3: begin
            thr_raw  = 15'($urandom_range(8000, 24000));
            gap_raw  = 15'h3FFF;
            low_raw  = {7'($urandom), 8'd0};
            high_raw = {7'($urandom), 8'd3};
          end
          4: begin
            thr_raw  = 15'($urandom_range(4000, 20000));
            gap_raw  = {1'($urandom), 14'd64};
            low_raw  = {7'($urandom), 8'($urandom_range(0, 3))};
            high_raw = {7'($urandom), 8'hFF};
          end
          5: begin
            thr_raw  = 15'($urandom_range(1000, 30000));
            gap_raw  = 15'($urandom_range(0, 300));
            low_raw  = '0;
            high_raw = 15'd2;
          end
          default: begin
            thr_raw  = ($urandom_range(0, 3) == 0) ? 15'($urandom) :
                       15'($urandom_range(2000, 28000));
            gap_raw  = {1'($urandom), ($urandom_range(0, 3) == 0) ? 14'($urandom) :
                                                                  14'($urandom_range(0, 250))};
            low_raw  = {7'($urandom), 8'($urandom_range(0, 3))};
            high_raw = {7'($urandom), 8'($urandom_range(2, 8))};
          end
        endcase
        program_regs(thr_raw, gap_raw, low_raw, high_raw);
      end

      phase_start  = beats_queued;
      phase_frames = 0;
      while (beats_queued - phase_start < 100 || phase_frames < 2) begin
        add_random_frame();
        phase_frames++;
      end
    end

    // frame that never ends: no verdict may appear
    repeat (12) push_beat(16'($urandom), 1'b0);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
